[src/ptbd_pkg.sv]
package ptbd_pkg;

   // Coordinate format: signed fixed point, two's complement.
   localparam int COORD_BITS = 24;
   localparam int DIST_BITS  = 26;

   // Absolute per-axis difference always fits in COORD_BITS unsigned bits.
   localparam int DIFF_BITS  = COORD_BITS;
   localparam int SQ_BITS    = 2 * DIFF_BITS;
   localparam int SUM_BITS   = SQ_BITS + 2;
   localparam int ROOT_BITS  = (SUM_BITS + 1) / 2;
   localparam int RAD_BITS   = 2 * ROOT_BITS;
   localparam int REM_BITS   = ROOT_BITS + 2;
   localparam int WIDE_BITS  = (ROOT_BITS > DIST_BITS) ? ROOT_BITS : DIST_BITS;

   localparam logic [WIDE_BITS-1:0] DIST_MAX =
      WIDE_BITS'((64'd1 << DIST_BITS) - 64'd1);

   // Clamp, square, sum, one stage per root bit, output register.
   localparam int LATENCY = ROOT_BITS + 4;

   typedef logic [COORD_BITS-1:0]       coord_type;
   typedef logic [2:0][COORD_BITS-1:0]  coord3_type;
   typedef logic [2:0][DIFF_BITS-1:0]   diff3_type;

   typedef struct packed {
      coord3_type nearest;
      logic       in_box;
   } side_type;

endpackage

[src/ptbd_clamp.sv]
module ptbd_clamp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  ptbd_pkg::coord3_type  point,
   input  ptbd_pkg::coord3_type  box_low,
   input  ptbd_pkg::coord3_type  box_high,
   output logic                  out_valid,
   output ptbd_pkg::side_type    side,
   output ptbd_pkg::diff3_type   diff
);
   import ptbd_pkg::*;

   logic [2:0]                below;
   logic [2:0]                above;
   logic signed [COORD_BITS:0] delta [3];
   side_type                  side_in, side_ff;
   diff3_type                 diff_in, diff_ff;
   logic                      valid_ff;

   // Clamp order: below low gives low, else above high gives high.
   always_comb begin
      side_in.in_box = 1'b1;
      for (int a = 0; a < 3; a++) begin
         below[a] = $signed(point[a]) < $signed(box_low[a]);
         above[a] = $signed(point[a]) > $signed(box_high[a]);
         if (below[a]) begin
            side_in.nearest[a] = box_low[a];
         end else if (above[a]) begin
            side_in.nearest[a] = box_high[a];
         end else begin
            side_in.nearest[a] = point[a];
         end
         if (below[a] || above[a]) begin
            side_in.in_box = 1'b0;
         end
         delta[a] = $signed({side_in.nearest[a][COORD_BITS-1], side_in.nearest[a]})
                  - $signed({point[a][COORD_BITS-1], point[a]});
         diff_in[a] = delta[a][COORD_BITS] ? DIFF_BITS'(-delta[a]) : DIFF_BITS'(delta[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      side_ff <= side_in;
      diff_ff <= diff_in;
   end

   assign out_valid = valid_ff;
   assign side      = side_ff;
   assign diff      = diff_ff;

endmodule

[src/ptbd_sqsum.sv]
module ptbd_sqsum (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  ptbd_pkg::side_type                in_side,
   input  ptbd_pkg::diff3_type               diff,
   output logic                              out_valid,
   output ptbd_pkg::side_type                out_side,
   output logic [ptbd_pkg::SUM_BITS-1:0]     sum
);
   import ptbd_pkg::*;

   logic [SQ_BITS-1:0]  sq_in [3];
   logic [SQ_BITS-1:0]  sq_ff [3];
   logic [SUM_BITS-1:0] sum_in, sum_ff;
   logic [1:0]          valid_ff;
   side_type            side_a_ff, side_b_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sq_in[a] = diff[a] * diff[a];
      end
      sum_in = SUM_BITS'(sq_ff[0]) + SUM_BITS'(sq_ff[1]) + SUM_BITS'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[0], in_valid};
      end
      for (int a = 0; a < 3; a++) begin
         sq_ff[a] <= sq_in[a];
      end
      side_a_ff <= in_side;
      sum_ff    <= sum_in;
      side_b_ff <= side_a_ff;
   end

   assign out_valid = valid_ff[1];
   assign out_side  = side_b_ff;
   assign sum       = sum_ff;

endmodule

[src/ptbd_isqrt.sv]
module ptbd_isqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  ptbd_pkg::side_type                in_side,
   input  logic [ptbd_pkg::SUM_BITS-1:0]     radicand,
   output logic                              out_valid,
   output ptbd_pkg::side_type                out_side,
   output logic [ptbd_pkg::ROOT_BITS-1:0]    root
);
   import ptbd_pkg::*;

   // One restoring step per stage: two radicand bits in, one root bit out.
   logic [ROOT_BITS-1:0] vld_in, vld_ff;
   logic [RAD_BITS-1:0]  cur_rad  [ROOT_BITS];
   logic [REM_BITS-1:0]  cur_rem  [ROOT_BITS];
   logic [ROOT_BITS-1:0] cur_root [ROOT_BITS];
   logic [REM_BITS-1:0]  shifted  [ROOT_BITS];
   logic [REM_BITS-1:0]  trial    [ROOT_BITS];
   logic [ROOT_BITS-1:0] take;
   logic [RAD_BITS-1:0]  rad_in   [ROOT_BITS];
   logic [RAD_BITS-1:0]  rad_ff   [ROOT_BITS];
   logic [REM_BITS-1:0]  rem_in   [ROOT_BITS];
   logic [REM_BITS-1:0]  rem_ff   [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_in  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff  [ROOT_BITS];
   side_type             side_in  [ROOT_BITS];
   side_type             side_ff  [ROOT_BITS];

   always_comb begin
      cur_rad[0]  = RAD_BITS'(radicand);
      cur_rem[0]  = '0;
      cur_root[0] = '0;
      vld_in[0]   = in_valid;
      side_in[0]  = in_side;
      for (int s = 1; s < ROOT_BITS; s++) begin
         cur_rad[s]  = rad_ff[s-1];
         cur_rem[s]  = rem_ff[s-1];
         cur_root[s] = root_ff[s-1];
         vld_in[s]   = vld_ff[s-1];
         side_in[s]  = side_ff[s-1];
      end
      for (int s = 0; s < ROOT_BITS; s++) begin
         shifted[s] = {cur_rem[s][REM_BITS-3:0], cur_rad[s][RAD_BITS-1 -: 2]};
         trial[s]   = {cur_root[s], 2'b01};
         take[s]    = shifted[s] >= trial[s];
         rem_in[s]  = take[s] ? (shifted[s] - trial[s]) : shifted[s];
         root_in[s] = {cur_root[s][ROOT_BITS-2:0], take[s]};
         rad_in[s]  = cur_rad[s] << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      for (int s = 0; s < ROOT_BITS; s++) begin
         rad_ff[s]  <= rad_in[s];
         rem_ff[s]  <= rem_in[s];
         root_ff[s] <= root_in[s];
         side_ff[s] <= side_in[s];
      end
   end

   assign out_valid = vld_ff[ROOT_BITS-1];
   assign out_side  = side_ff[ROOT_BITS-1];
   assign root      = root_ff[ROOT_BITS-1];

endmodule

[src/point_to_box_distance_top.sv]
// Point to axis-aligned box distance, fully pipelined.
//
// Input channel: drive the point and both box corners on the req_ ports and
// raise start. A beat is taken at each rising edge where start is high and
// busy is low. Busy is low at all times outside reset, so a new beat may be
// issued in every cycle and the block sustains one query per clock.
// Result channel: every query returns exactly one beat, in issue order, with
// rsp_valid high for a single cycle. It carries the clamped nearest point,
// the floor of the Euclidean distance (unsigned, coordinate scale, saturating
// at the top of its range) and a flag that is set when the point lies within
// the box. From the accepting edge to the edge that takes the result, a beat
// passes one clamp stage, a squaring stage, a summing stage, one stage per bit
// of the square root and an output register; the square root pipeline
// holds most of these stages.
// Reset is synchronous and clears all valid bits, so beats in flight are
// dropped; busy is high while reset is held. The receiver has no way to
// stall the result channel and must take each beat when it is shown.
module point_to_box_distance_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  ptbd_pkg::coord_type                req_point_x,
   input  ptbd_pkg::coord_type                req_point_y,
   input  ptbd_pkg::coord_type                req_point_z,
   input  ptbd_pkg::coord_type                req_box_low_x,
   input  ptbd_pkg::coord_type                req_box_low_y,
   input  ptbd_pkg::coord_type                req_box_low_z,
   input  ptbd_pkg::coord_type                req_box_high_x,
   input  ptbd_pkg::coord_type                req_box_high_y,
   input  ptbd_pkg::coord_type                req_box_high_z,
   output logic                               rsp_valid,
   output ptbd_pkg::coord_type                rsp_nearest_x,
   output ptbd_pkg::coord_type                rsp_nearest_y,
   output ptbd_pkg::coord_type                rsp_nearest_z,
   output logic [ptbd_pkg::DIST_BITS-1:0]     rsp_distance,
   output logic                               rsp_inside_res
);
   import ptbd_pkg::*;

   logic                  accept;
   coord3_type            point, box_low, box_high;

   logic                  clamp_valid;
   side_type              clamp_side;
   diff3_type             clamp_diff;

   logic                  sum_valid;
   side_type              sum_side;
   logic [SUM_BITS-1:0]   sum;

   logic                  root_valid;
   side_type              root_side;
   logic [ROOT_BITS-1:0]  root;

   logic [WIDE_BITS-1:0]  dist_wide;
   logic [DIST_BITS-1:0]  dist_in;

   logic                  rsp_valid_ff;
   side_type              rsp_side_ff;
   logic [DIST_BITS-1:0]  rsp_dist_ff;

   // Nothing downstream can push back, so the only time a beat is refused
   // is while reset is held.
   assign busy   = reset;
   assign accept = start && !busy;

   assign point    = {req_point_z, req_point_y, req_point_x};
   assign box_low  = {req_box_low_z, req_box_low_y, req_box_low_x};
   assign box_high = {req_box_high_z, req_box_high_y, req_box_high_x};

   ptbd_clamp u_clamp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .point     (point),
      .box_low   (box_low),
      .box_high  (box_high),
      .out_valid (clamp_valid),
      .side      (clamp_side),
      .diff      (clamp_diff)
   );

   ptbd_sqsum u_sqsum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (clamp_valid),
      .in_side   (clamp_side),
      .diff      (clamp_diff),
      .out_valid (sum_valid),
      .out_side  (sum_side),
      .sum       (sum)
   );

   ptbd_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_side   (sum_side),
      .radicand  (sum),
      .out_valid (root_valid),
      .out_side  (root_side),
      .root      (root)
   );

   // The root can only exceed the distance field with wide coordinates;
   // it then saturates at the field's maximum.
   always_comb begin
      dist_wide = WIDE_BITS'(root);
      if (dist_wide > DIST_MAX) begin
         dist_in = DIST_BITS'(DIST_MAX);
      end else begin
         dist_in = DIST_BITS'(dist_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= root_valid;
      end
      rsp_side_ff <= root_side;
      rsp_dist_ff <= dist_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_nearest_x  = rsp_side_ff.nearest[0];
   assign rsp_nearest_y  = rsp_side_ff.nearest[1];
   assign rsp_nearest_z  = rsp_side_ff.nearest[2];
   assign rsp_distance   = rsp_dist_ff;
   assign rsp_inside_res = rsp_side_ff.in_box;

`ifndef NO_ASSERTIONS
   // Every accepted beat comes out after the fixed pipeline latency.
   a_latency_out: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted beat did not produce a result on time");

   // No result appears without a beat accepted the pipeline depth earlier.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result without a matching accepted beat");

   // A point inside the box is its own nearest point, at distance zero.
   a_inside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_inside_res) |-> (rsp_distance == '0))
      else $error("inside point reported with nonzero distance");
`endif

endmodule
